@@ rtl/core/mf3_pkg.sv @@
`default_nettype none

package mf3_pkg;

  localparam int MAX_SIZE  = 512;
  localparam int SIZE_W    = 10;
  localparam int PIX_W     = 16;
  localparam int COL_W     = $clog2(MAX_SIZE);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;

  // one column push for the back end
  typedef struct packed {
    col_t col;
    pix_t value;
    logic emit;
    logic border;
    logic frame_end;
  } work_t;

  typedef struct packed {
    pix_t value;
    logic frame_end;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/mf3_ram.sv @@
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mf3_front.sv @@
`default_nettype none

module mf3_front
  import mf3_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] image_size,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              command,
  input  wire pix_t              pixel_value,
  input  wire logic              q_full,
  output logic                   q_push,
  output work_t                  q_word
);

  col_t size_last;
  col_t cfg_last;
  col_t push_col;
  col_t acc_row;
  col_t qx;
  col_t qy;
  logic full;
  logic emit_on;

  logic accept;
  logic is_pixel;
  logic at_col_last;
  logic q_col_last;
  logic q_row_last;
  logic cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign is_pixel  = (command == CMD_PIXEL);

  assign at_col_last = (push_col == size_last);
  assign q_col_last  = (qx == size_last);
  assign q_row_last  = (qy == size_last);

  // size clamped to 3..MAX_SIZE, kept as size minus one
  always_comb begin
    if (image_size < SIZE_W'(3)) begin
      cfg_last = COL_W'(2);
    end else if (32'(image_size) > MAX_SIZE) begin
      cfg_last = COL_W'(MAX_SIZE - 1);
    end else begin
      cfg_last = COL_W'(image_size - SIZE_W'(1));
    end
  end

  always_comb begin
    q_push          = accept && (is_pixel ? !full : full);
    q_word.col      = push_col;
    q_word.value    = is_pixel ? pixel_value : '0;
    q_word.emit     = is_pixel ? emit_on : 1'b1;
    q_word.border   = (qx == '0) || q_col_last || (qy == '0) || q_row_last;
    q_word.frame_end = q_word.emit && q_col_last && q_row_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_last <= COL_W'(MAX_SIZE - 1);
      push_col  <= '0;
      acc_row   <= '0;
      qx        <= '0;
      qy        <= '0;
      full      <= 1'b0;
      emit_on   <= 1'b0;
    end else if (cfg_write) begin
      size_last <= cfg_last;
      push_col  <= '0;
      acc_row   <= '0;
      qx        <= '0;
      qy        <= '0;
      full      <= 1'b0;
      emit_on   <= 1'b0;
    end else if (q_push) begin
      if (q_word.frame_end) begin
        push_col <= '0;
        acc_row  <= '0;
        qx       <= '0;
        qy       <= '0;
        full     <= 1'b0;
        emit_on  <= 1'b0;
      end else begin
        push_col <= at_col_last ? '0 : push_col + COL_W'(1);
        if (is_pixel) begin
          if (at_col_last) begin
            acc_row <= acc_row + COL_W'(1);
          end
          if ((acc_row == COL_W'(1)) && (push_col == '0)) begin
            emit_on <= 1'b1;
          end
          if ((acc_row == size_last) && at_col_last) begin
            full <= 1'b1;
          end
        end
        if (q_word.emit) begin
          qx <= q_col_last ? '0 : qx + COL_W'(1);
          if (q_col_last) begin
            qy <= qy + COL_W'(1);
          end
        end
      end
    end
  end

  a_frame_end_after_full: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_word.frame_end) |-> full)
    else $error("frame end before the frame was complete");

  a_full_implies_emit: assert property (@(posedge clk) disable iff (rst)
    full |-> emit_on)
    else $error("frame complete without emission started");

endmodule

`default_nettype wire

@@ rtl/core/mf3_queue.sv @@
`default_nettype none

module mf3_queue
  import mf3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire work_t push_word,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output work_t      head
);

  work_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QUEUE_AW'(1);
      end
      priority if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("work queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("work queue underflow");

endmodule

`default_nettype wire

@@ rtl/core/mf3_back.sv @@
`default_nettype none

module mf3_back
  import mf3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  wire work_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_word
);

  typedef struct packed {
    pix_t lo0, lo1, lo2;
    pix_t mi0, mi1, mi2;
    pix_t hi0, hi1, hi2;
    pix_t center;
    logic border;
    logic frame_end;
  } rows_t;

  typedef struct packed {
    pix_t a, b, c;
    pix_t center;
    logic border;
    logic frame_end;
  } tri_t;

  function automatic pix_t min2(pix_t x, pix_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic pix_t max2(pix_t x, pix_t y);
    return (x < y) ? y : x;
  endfunction

  function automatic pix_t med3(pix_t x, pix_t y, pix_t z);
    return max2(min2(x, y), min2(max2(x, y), z));
  endfunction

  // line store: upper half older row, lower half newer row
  logic [2*PIX_W-1:0] ram_rdata;
  logic [2*PIX_W-1:0] line_col;
  logic [2*PIX_W-1:0] wr_data;
  logic               fwd_hit;
  logic [2*PIX_W-1:0] fwd_data;

  work_t p1;
  logic  p1_valid;
  logic  p2_valid;
  logic  p2_border;
  logic  p2_frame_end;
  rows_t p3;
  logic  p3_valid;
  tri_t  p4;
  logic  p4_valid;

  pix_t win [3][3];

  res_t              out_mem [OUT_DEPTH];
  logic [OUT_AW-1:0] out_wr_ptr;
  logic [OUT_AW-1:0] out_rd_ptr;
  logic [OUT_CW-1:0] out_count;
  logic [OUT_CW:0]   credit_sum;
  logic              out_pop;
  rows_t             rows_d;
  tri_t              tri_d;
  res_t              res_d;

  // words that may still reach the output buffer
  assign credit_sum = {1'b0, out_count}
                    + (OUT_CW+1)'(p1_valid && p1.emit)
                    + (OUT_CW+1)'(p2_valid)
                    + (OUT_CW+1)'(p3_valid)
                    + (OUT_CW+1)'(p4_valid);
  assign q_pop = !q_empty && (credit_sum < (OUT_CW+1)'(OUT_DEPTH));

  mf3_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_SIZE)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (p1_valid),
    .wr_addr (p1.col),
    .wr_data (wr_data),
    .rd_en   (q_pop),
    .rd_addr (q_head.col),
    .rd_data (ram_rdata)
  );

  assign line_col = fwd_hit ? fwd_data : ram_rdata;
  assign wr_data  = {line_col[PIX_W-1:0], p1.value};

  // same column pushed twice in a row at a frame boundary
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= q_pop && p1_valid && (p1.col == q_head.col);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wr_data;
    if (q_pop) begin
      p1 <= q_head;
    end
    if (p1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= line_col[2*PIX_W-1:PIX_W];
      win[1][2] <= line_col[PIX_W-1:0];
      win[2][2] <= p1.value;
      p2_border    <= p1.border;
      p2_frame_end <= p1.frame_end;
    end
    p3 <= rows_d;
    p4 <= tri_d;
  end

  always_comb begin
    rows_d.lo0 = min2(min2(win[0][0], win[0][1]), win[0][2]);
    rows_d.mi0 = med3(win[0][0], win[0][1], win[0][2]);
    rows_d.hi0 = max2(max2(win[0][0], win[0][1]), win[0][2]);
    rows_d.lo1 = min2(min2(win[1][0], win[1][1]), win[1][2]);
    rows_d.mi1 = med3(win[1][0], win[1][1], win[1][2]);
    rows_d.hi1 = max2(max2(win[1][0], win[1][1]), win[1][2]);
    rows_d.lo2 = min2(min2(win[2][0], win[2][1]), win[2][2]);
    rows_d.mi2 = med3(win[2][0], win[2][1], win[2][2]);
    rows_d.hi2 = max2(max2(win[2][0], win[2][1]), win[2][2]);
    rows_d.center    = win[1][1];
    rows_d.border    = p2_border;
    rows_d.frame_end = p2_frame_end;

    tri_d.a         = max2(max2(p3.lo0, p3.lo1), p3.lo2);
    tri_d.b         = med3(p3.mi0, p3.mi1, p3.mi2);
    tri_d.c         = min2(min2(p3.hi0, p3.hi1), p3.hi2);
    tri_d.center    = p3.center;
    tri_d.border    = p3.border;
    tri_d.frame_end = p3.frame_end;

    res_d.value     = p4.border ? p4.center : med3(p4.a, p4.b, p4.c);
    res_d.frame_end = p4.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else begin
      p1_valid <= q_pop;
      p2_valid <= p1_valid && p1.emit;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  // output buffer
  assign out_valid = (out_count != '0);
  assign out_word  = out_mem[out_rd_ptr];
  assign out_pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (p4_valid) begin
      out_mem[out_wr_ptr] <= res_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      if (p4_valid) begin
        out_wr_ptr <= (out_wr_ptr == OUT_AW'(OUT_DEPTH - 1)) ? '0 : out_wr_ptr + OUT_AW'(1);
      end
      if (out_pop) begin
        out_rd_ptr <= (out_rd_ptr == OUT_AW'(OUT_DEPTH - 1)) ? '0 : out_rd_ptr + OUT_AW'(1);
      end
      priority if (p4_valid && !out_pop) begin
        out_count <= out_count + OUT_CW'(1);
      end else if (out_pop && !p4_valid) begin
        out_count <= out_count - OUT_CW'(1);
      end
    end
  end

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    p4_valid |-> (out_count < OUT_CW'(OUT_DEPTH)))
    else $error("output buffer overflow");

  a_forward_needs_write: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> $past(p1_valid))
    else $error("line store bypass without a write");

endmodule

`default_nettype wire

@@ rtl/core/median_filter_3x3_core.sv @@
`default_nettype none

// 3x3 median filter over a square image of image_size pixels (clamped to 3..512)
// streamed in raster order. Each pixel word comes back delayed by one row plus one
// pixel: interior pixels as the median of their 3x3 neighbourhood, border pixels
// unchanged. After the last pixel of a frame, send one flush word per pending pixel
// (image_size plus one of them); the last result carries frame_end, and the next
// frame starts. Pixel words after a complete frame and flush words before one are
// taken and dropped. The core takes one word per clock and gives one result per
// clock unless out_ready or a full work queue holds it; each result passes the
// line store read and the three-stage median network before the output buffer. A
// write to image_size restarts the frame; the line store needs no clearing.
module median_filter_3x3_core
  import mf3_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] image_size,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              command,
  input  wire logic [PIX_W-1:0]  pixel_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PIX_W-1:0]       filtered_value,
  output logic                   frame_end
);

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_empty;
  work_t q_word;
  work_t q_head;
  res_t  out_word;

  mf3_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .image_size  (image_size),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .pixel_value (pixel_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_word      (q_word)
  );

  mf3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_word),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  mf3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign filtered_value = out_word.value;
  assign frame_end      = out_word.frame_end;

endmodule

`default_nettype wire

@@ tb/tb_median_filter_3x3_core.sv @@
`timescale 1ns / 100ps

module tb_median_filter_3x3_core;
  import mf3_pkg::*;

  localparam int MAX_SHOWN     = 10;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_WORDS  = 500;
  localparam int WIDE_WORDS    = 600;

  typedef struct packed {
    logic cmd;
    pix_t pix;
    logic known;
    logic has_out;
    res_t want;
  } vec_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] image_size = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              command = CMD_PIXEL;
  logic [PIX_W-1:0]  pixel_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PIX_W-1:0]  filtered_value;
  logic              frame_end;

  median_filter_3x3_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .image_size     (image_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .pixel_value    (pixel_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .frame_end      (frame_end)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // filter state as the stream sees it
  logic [SIZE_W-1:0] side_reg;
  pix_t              row_mem [0:2*MAX_SIZE-1];
  pix_t              nbhd [0:8];
  int unsigned       taken_cnt;
  int unsigned       given_cnt;

  res_t awaited_pixels [$];
  vec_t dir_vec [16];

  int gap_max = 8;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_wait = 0;
  int rx_draw;

  int err_count = 0;
  int results_checked = 0;
  int taken_words = 0;
  int dropped_words = 0;
  int size_writes = 0;

  function automatic int unsigned side_len();
    int unsigned n;
    n = side_reg;
    if (n < 3) n = 3;
    if (n > MAX_SIZE) n = MAX_SIZE;
    return n;
  endfunction

  function automatic pix_t middle_of_nine();
    pix_t s [9];
    pix_t k;
    int   i, j;
    for (i = 0; i < 9; i++) s[i] = nbhd[i];
    for (i = 1; i < 9; i++) begin
      k = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > k) begin
        s[j + 1] = s[j];
        j--;
      end
      s[j + 1] = k;
    end
    return s[4];
  endfunction

  function automatic void shift_column(int unsigned pos, int unsigned n, pix_t val);
    int unsigned x;
    pix_t        col [3];
    int          r;
    x = pos % n;
    col[0] = row_mem[MAX_SIZE + x];
    col[1] = row_mem[x];
    col[2] = val;
    row_mem[MAX_SIZE + x] = row_mem[x];
    row_mem[x] = val;
    for (r = 0; r < 3; r++) begin
      nbhd[r*3 + 0] = nbhd[r*3 + 1];
      nbhd[r*3 + 1] = nbhd[r*3 + 2];
      nbhd[r*3 + 2] = col[r];
    end
  endfunction

  function automatic res_t emit_centre(int unsigned n);
    int unsigned qx, qy;
    res_t        r;
    qx = given_cnt % n;
    qy = given_cnt / n;
    r.value = (qx == 0 || qx == n - 1 || qy == 0 || qy == n - 1) ? nbhd[4] : middle_of_nine();
    r.frame_end = 1'b0;
    given_cnt++;
    if (given_cnt >= n * n) begin
      r.frame_end = 1'b1;
      taken_cnt = 0;
      given_cnt = 0;
    end
    return r;
  endfunction

  function automatic bit filter_word(logic cmd, pix_t pix, output res_t r, output bit took);
    int unsigned n, total, v;
    n = side_len();
    total = n * n;
    r = '0;
    took = 1'b0;
    if (cmd == CMD_PIXEL) begin
      if (taken_cnt >= total) return 1'b0;
      v = taken_cnt;
      took = 1'b1;
      shift_column(v, n, pix);
      taken_cnt++;
      if (v >= n + 1) begin
        r = emit_centre(n);
        return 1'b1;
      end
      return 1'b0;
    end
    if (taken_cnt < total || given_cnt >= total) return 1'b0;
    took = 1'b1;
    shift_column(given_cnt + n + 1, n, '0);
    r = emit_centre(n);
    return 1'b1;
  endfunction

  function automatic pix_t rand_pix();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return pix_t'($urandom_range(0, 3));
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0: return SIZE_W'($urandom_range(0, 2));
      1: return SIZE_W'($urandom_range(13, 20));
      default: return SIZE_W'($urandom_range(3, 12));
    endcase
  endfunction

  task automatic send_word(logic cmd, pix_t pix, bit typed = 1'b0, bit typed_has = 1'b0,
                           res_t typed_res = '0);
    int unsigned gap;
    bit          got, took;
    res_t        r;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    pixel_value <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = filter_word(cmd, pix, r, took);
    if (typed) begin
      got = typed_has;
      r = typed_res;
    end
    if (got) awaited_pixels.insert(awaited_pixels.size(), r);
    if (took) taken_words++;
    else dropped_words++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    cfg_valid  <= 1'b1;
    image_size <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    side_reg = v;
    taken_cnt = 0;
    given_cnt = 0;
    size_writes++;
  endtask

  task automatic run_frame(int unsigned n, bit noise, bit pause);
    int unsigned i;
    for (i = 0; i < n * n; i++) begin
      if (noise && $urandom_range(0, 31) == 0) send_word(CMD_FLUSH, rand_pix());
      if (pause && i == n * n / 2) settle();
      send_word(CMD_PIXEL, rand_pix());
    end
    if (noise && $urandom_range(0, 3) == 0) send_word(CMD_PIXEL, rand_pix());
    for (i = 0; i <= n; i++) send_word(CMD_FLUSH, rand_pix());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) out_ready <= 1'b1;
    end else if (out_valid && out_ready) begin
      rx_draw = $urandom_range(0, gap_max);
      rx_wait   <= rx_draw;
      out_ready <= (rx_draw == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      if (rx_wait == 1) out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_out
    res_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (awaited_pixels.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("%0t: unexpected word value %h end %b", $time, filtered_value, frame_end);
      end else begin
        want = awaited_pixels.pop_front();
        if (want.value !== filtered_value || want.frame_end !== frame_end) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("%0t: word %0d expected %h end %b, got %h end %b", $time,
                     results_checked, want.value, want.frame_end, filtered_value, frame_end);
        end
      end
    end
  end

  initial begin : stim
    int unsigned n, base, kind;
    int          i;
    side_reg = SIZE_W'(MAX_SIZE);
    for (i = 0; i < 2 * MAX_SIZE; i++) row_mem[i] = '0;
    for (i = 0; i < 9; i++) nbhd[i] = '0;
    taken_cnt = 0;
    given_cnt = 0;

    // 3x3 frame: pixel q comes back on taken word q+4 (flushes too), centre is the median
    dir_vec = '{
      '{CMD_FLUSH, 16'h1234, 1'b1, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_PIXEL, 16'h0000, 1'b1, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_PIXEL, 16'hFFFF, 1'b1, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_PIXEL, 16'h0001, 1'b1, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_PIXEL, 16'h8000, 1'b1, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_PIXEL, 16'h0007, 1'b1, 1'b1, '{16'h0000, 1'b0}},
      '{CMD_PIXEL, 16'hFFFE, 1'b1, 1'b1, '{16'hFFFF, 1'b0}},
      '{CMD_PIXEL, 16'h0002, 1'b1, 1'b1, '{16'h0001, 1'b0}},
      '{CMD_PIXEL, 16'h0064, 1'b1, 1'b1, '{16'h8000, 1'b0}},
      '{CMD_PIXEL, 16'h9C40, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_PIXEL, 16'h5555, 1'b1, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_FLUSH, 16'hAAAA, 1'b1, 1'b1, '{16'hFFFE, 1'b0}},
      '{CMD_FLUSH, 16'h0000, 1'b1, 1'b1, '{16'h0002, 1'b0}},
      '{CMD_FLUSH, 16'hFFFF, 1'b1, 1'b1, '{16'h0064, 1'b0}},
      '{CMD_FLUSH, 16'h0000, 1'b1, 1'b1, '{16'h9C40, 1'b1}},
      '{CMD_FLUSH, 16'h0000, 1'b1, 1'b0, '{16'h0000, 1'b0}}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_size('0);
    foreach (dir_vec[k])
      send_word(dir_vec[k].cmd, dir_vec[k].pix, dir_vec[k].known, dir_vec[k].has_out,
                dir_vec[k].want);
    settle();

    // output held off while input keeps coming
    gap_max <= 0;
    write_size(SIZE_W'(6));
    hold_asked <= hold_asked + 1;
    run_frame(6, 1'b0, 1'b0);
    settle();

    base = taken_words;
    while (taken_words - base < RANDOM_WORDS) begin
      gap_max <= ($urandom_range(0, 3) == 0) ? 0 : 8;
      write_size(pick_size());
      n = side_len();
      repeat ($urandom_range(1, 3)) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          run_frame(n, 1'b1, 1'b0);
        end else if (kind == 7) begin
          run_frame(n, 1'b1, 1'b1);
        end else if (kind == 8) begin
          repeat ($urandom_range(1, 30))
            send_word(($urandom_range(0, 1) != 0) ? CMD_FLUSH : CMD_PIXEL, rand_pix());
        end else begin
          repeat ($urandom_range(1, n * n + n))
            send_word(($urandom_range(0, 7) == 0) ? CMD_FLUSH : CMD_PIXEL, rand_pix());
        end
      end
      settle();
    end

    // largest size, no idling
    gap_max <= 0;
    settle();
    write_size('1);
    repeat (WIDE_WORDS) send_word(CMD_PIXEL, rand_pix());
    settle();

    $display("checked %0d results from %0d words, %0d of them dropped, over %0d size writes",
             results_checked, taken_words + dropped_words, dropped_words, size_writes);
    $display("sizes clamped low, 3 to 20 and clamped high to 512, with stalls on both sides");
    if (err_count == 0 && awaited_pixels.size() == 0) begin
      $display("tb_median_filter_3x3_core: done, clean");
    end else begin
      $display("tb_median_filter_3x3_core: done, errors");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("timeout with %0d results outstanding", awaited_pixels.size());
    $display("tb_median_filter_3x3_core: done, errors");
    $finish;
  end

endmodule

@@ median_filter_3x3_core.f @@
rtl/core/mf3_pkg.sv
rtl/core/mf3_ram.sv
rtl/core/mf3_front.sv
rtl/core/mf3_queue.sv
rtl/core/mf3_back.sv
rtl/core/median_filter_3x3_core.sv
tb/tb_median_filter_3x3_core.sv
